[hdl/i2p_pkg.sv]
// Shared types, character codes and classification functions for the
// infix to postfix converter. Used by i2p_front, i2p_back and the top level.
package i2p_pkg;

	// Default number of operator stack entries.
	localparam int STACK_DEPTH_DEF = 32;

	// Depth of the command queue between the front and back parts.
	localparam int Q_DEPTH = 2;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NONE  = 8'h00;

	// Character classes as decided by the front part.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_OPND = 2'd0;
	localparam kind_t KIND_LPAR = 2'd1;
	localparam kind_t KIND_RPAR = 2'd2;
	localparam kind_t KIND_OPER = 2'd3;

	// Operator ranks; a stacked '(' ranks lowest.
	typedef logic [1:0] rank_t;
	localparam rank_t RANK_PAREN = 2'd0;
	localparam rank_t RANK_ADD   = 2'd1;
	localparam rank_t RANK_MUL   = 2'd2;
	localparam rank_t RANK_OTHER = 2'd3;

	// One classified character as it travels from front to back.
	typedef struct packed {
		logic [7:0] ch;
		logic       final_req;
		kind_t      kind;
		rank_t      rank;
	} cmd_t;

	// Rank of a character when it sits on, or goes onto, the stack.
	function automatic rank_t rank_of(input logic [7:0] c);
		rank_t r;
		if (c == CH_LPAR) begin
			r = RANK_PAREN;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			r = RANK_ADD;
		end else if (c == CH_STAR || c == CH_SLASH) begin
			r = RANK_MUL;
		end else begin
			r = RANK_OTHER;
		end
		return r;
	endfunction

	// True for ASCII letters and digits, which pass straight to the output.
	function automatic logic is_opnd(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

[hdl/i2p_front.sv]
// Front part of the infix to postfix converter: accepts characters,
// classifies them and holds them in a short command queue. Depends on i2p_pkg.
module i2p_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    ch,
	input  logic          final_req,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output i2p_pkg::cmd_t cmd
);
	import i2p_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t            q_data_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   q_cnt_q;
	logic            accept;
	cmd_t            new_cmd;

	// Classify the incoming character.
	always_comb begin
		new_cmd.ch        = ch;
		new_cmd.final_req = final_req;
		new_cmd.rank      = rank_of(ch);
		if (is_opnd(ch)) begin
			new_cmd.kind = KIND_OPND;
		end else if (ch == CH_LPAR) begin
			new_cmd.kind = KIND_LPAR;
		end else if (ch == CH_RPAR) begin
			new_cmd.kind = KIND_RPAR;
		end else begin
			new_cmd.kind = KIND_OPER;
		end
	end

	assign in_stall  = (q_cnt_q == CW'(Q_DEPTH));
	assign accept    = in_valid && !in_stall;
	assign cmd_valid = (q_cnt_q != '0);
	assign cmd       = q_data_q[rd_ptr_q];

	// Queue storage; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			q_data_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (accept && !cmd_take) begin
				q_cnt_q <= q_cnt_q + 1'b1;
			end else if (cmd_take && !accept) begin
				q_cnt_q <= q_cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/i2p_back.sv]
// Back part of the infix to postfix converter: operator stack, pop sequencer
// and output register. Depends on i2p_pkg.
module i2p_back #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  i2p_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_char,
	output logic          terminator,
	output logic          run_end,
	output logic          overflow,
	output logic          unmatched
);
	import i2p_pkg::*;

	localparam int IW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_OPS   = 2'd1;
	localparam logic [1:0] ST_RPAR  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	// Stack: the top entry lives in top_q, the rest in stk_mem, and the entry
	// just under the top is kept ready in below_q.
	logic [7:0]    stk_mem [STACK_DEPTH];
	logic [7:0]    top_q;
	logic [7:0]    below_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] paren_q;
	logic [1:0]    state_q;
	cmd_t          cur_q;
	logic          ovf_q;
	logic          unm_q;

	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          term_q;
	logic          last_q;
	logic          out_ovf_q;
	logic          out_unm_q;

	logic          adv;
	logic          stk_empty;
	logic          stk_full;
	logic          one_left;
	rank_t         top_rank;
	rank_t         below_rank;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m3;
	logic [IW-1:0] waddr;
	logic [IW-1:0] raddr;

	logic          do_push;
	logic [7:0]    push_data;
	logic          do_pop;
	logic          emit;
	logic [7:0]    emit_char;
	logic          emit_term;
	logic          emit_last;
	logic          ld_cmd;
	logic          nxt_ovf;
	logic          nxt_unm;
	logic          paren_inc;
	logic          paren_dec;
	logic          paren_clr;
	logic [1:0]    nxt_state;

	assign adv        = !out_valid_q || !out_stall;
	assign stk_empty  = (cnt_q == '0);
	assign stk_full   = (cnt_q == CW'(STACK_DEPTH));
	assign one_left   = (cnt_q == CW'(1));
	assign top_rank   = rank_of(top_q);
	assign below_rank = rank_of(below_q);
	assign cnt_m1     = cnt_q - CW'(1);
	assign cnt_m3     = cnt_q - CW'(3);
	assign waddr      = cnt_m1[IW-1:0];
	assign raddr      = cnt_m3[IW-1:0];

	// Sequencer: at most one stack move and one result per cycle.
	always_comb begin
		do_push   = 1'b0;
		push_data = cur_q.ch;
		do_pop    = 1'b0;
		emit      = 1'b0;
		emit_char = CH_NONE;
		emit_term = 1'b0;
		emit_last = 1'b0;
		ld_cmd    = 1'b0;
		cmd_take  = 1'b0;
		nxt_ovf   = ovf_q;
		nxt_unm   = unm_q;
		paren_inc = 1'b0;
		paren_dec = 1'b0;
		paren_clr = 1'b0;
		nxt_state = state_q;
		if (adv) begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_take = 1'b1;
						ld_cmd   = 1'b1;
						nxt_ovf  = 1'b0;
						nxt_unm  = 1'b0;
						unique case (cmd.kind)
							KIND_OPND: begin
								emit      = 1'b1;
								emit_char = cmd.ch;
								emit_last = !cmd.final_req;
								if (cmd.final_req) begin
									nxt_state = ST_DRAIN;
								end
							end
							KIND_LPAR: begin
								if (stk_full) begin
									nxt_ovf = 1'b1;
								end else begin
									do_push   = 1'b1;
									push_data = cmd.ch;
									paren_inc = 1'b1;
								end
								if (cmd.final_req) begin
									nxt_state = ST_DRAIN;
								end else if (stk_full) begin
									// Flag-only result for a dropped push.
									emit      = 1'b1;
									emit_last = 1'b1;
								end
							end
							KIND_RPAR: begin
								nxt_unm = (paren_q == '0);
								if (stk_empty) begin
									if (cmd.final_req) begin
										nxt_state = ST_DRAIN;
									end else begin
										// Flag-only result for a bare ')'.
										emit      = 1'b1;
										emit_last = 1'b1;
									end
								end else begin
									nxt_state = ST_RPAR;
								end
							end
							KIND_OPER: begin
								nxt_state = ST_OPS;
							end
						endcase
					end
				end
				ST_OPS: begin
					if (!stk_empty && top_rank >= cur_q.rank) begin
						do_pop    = 1'b1;
						emit      = 1'b1;
						emit_char = top_q;
						emit_last = !cur_q.final_req &&
							(one_left || below_rank < cur_q.rank);
					end else begin
						if (stk_full) begin
							nxt_ovf = 1'b1;
						end else begin
							do_push = 1'b1;
						end
						if (cur_q.final_req) begin
							nxt_state = ST_DRAIN;
						end else begin
							nxt_state = ST_IDLE;
							if (stk_full) begin
								emit      = 1'b1;
								emit_last = 1'b1;
							end
						end
					end
				end
				ST_RPAR: begin
					if (stk_empty) begin
						nxt_state = cur_q.final_req ? ST_DRAIN : ST_IDLE;
					end else if (top_q == CH_LPAR) begin
						// The matching '(' is dropped without a result.
						do_pop    = 1'b1;
						paren_dec = 1'b1;
						nxt_state = cur_q.final_req ? ST_DRAIN : ST_IDLE;
					end else begin
						do_pop    = 1'b1;
						emit      = 1'b1;
						emit_char = top_q;
						emit_last = !cur_q.final_req && (one_left || below_q == CH_LPAR);
					end
				end
				ST_DRAIN: begin
					if (!stk_empty) begin
						do_pop    = 1'b1;
						emit      = 1'b1;
						emit_char = top_q;
					end else begin
						emit      = 1'b1;
						emit_term = 1'b1;
						emit_last = 1'b1;
						paren_clr = 1'b1;
						nxt_state = ST_IDLE;
					end
				end
			endcase
		end
	end

	// Stack memory write: the old top moves down on a push.
	always_ff @(posedge clk) begin
		if (do_push && !stk_empty) begin
			stk_mem[waddr] <= top_q;
		end
	end

	// Top and next-below entries; the read runs one pop ahead.
	always_ff @(posedge clk) begin
		if (do_push) begin
			top_q   <= push_data;
			below_q <= top_q;
		end else if (do_pop) begin
			top_q   <= below_q;
			below_q <= stk_mem[raddr];
		end
	end

	// Current command payload.
	always_ff @(posedge clk) begin
		if (ld_cmd) begin
			cur_q <= cmd;
		end
	end

	// Control state, counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			paren_q <= '0;
			ovf_q   <= 1'b0;
			unm_q   <= 1'b0;
		end else begin
			state_q <= nxt_state;
			ovf_q   <= nxt_ovf;
			unm_q   <= nxt_unm;
			if (do_push) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop) begin
				cnt_q <= cnt_m1;
			end
			if (paren_clr) begin
				paren_q <= '0;
			end else if (paren_inc) begin
				paren_q <= paren_q + CW'(1);
			end else if (paren_dec) begin
				paren_q <= paren_q - CW'(1);
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			term_q     <= emit_term;
			last_q     <= emit_last;
			out_ovf_q  <= nxt_ovf;
			out_unm_q  <= nxt_unm;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign terminator = term_q;
	assign run_end    = last_q;
	assign overflow   = out_ovf_q;
	assign unmatched  = out_unm_q;

endmodule

[hdl/infix_to_postfix_converter.sv]
// Top level of the infix to postfix converter: joins the classifying front
// part to the stack sequencer through a command queue. Depends on i2p_pkg.
//
// Usage: characters of an infix expression enter on the input channel
// (in_valid, in_stall, ch, final_req), one per transaction, final_req set on
// the last one. Postfix characters leave on the output channel (out_valid,
// out_stall, out_char, terminator, run_end, overflow, unmatched); each input
// gives zero or more results and run_end marks the last of them.
// A letter or digit accepted while the queue is empty passes through the queue
// entry and then the output register. The sequencer takes each command in
// ST_IDLE; it spends a step on each result it sends and on each stack push or
// dropped '(', and an extra step to fetch an operator or ')'.
// The front queue holds two transactions, so the input keeps flowing while
// the back part pops. A stalled output freezes the sequencer, the queue then
// fills and in_stall rises. Reset empties the queue and the operator stack;
// there is no clearing pass and the first character can enter at once.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       final_req,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       terminator,
	output logic       run_end,
	output logic       overflow,
	output logic       unmatched
);
	import i2p_pkg::*;

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	// Front part: classification and command queue.
	i2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.final_req (final_req),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	// Back part: operator stack and result generation.
	i2p_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_take   (cmd_take),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.terminator (terminator),
		.run_end    (run_end),
		.overflow   (overflow),
		.unmatched  (unmatched)
	);

endmodule
